// ----- rtl/stereo_soft_knee_compressor_defines.svh -----
// Assertion macros used by the compressor top level.
`ifndef STEREO_SOFT_KNEE_COMPRESSOR_DEFINES_SVH
`define STEREO_SOFT_KNEE_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define SSK_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define SSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ssk_pkg.sv -----
// Shared types, constants and ROM tables of the soft-knee compressor.
`default_nettype none
package ssk_pkg;

  // gain recompute interval and log table size
  localparam int DECIMATE        = 16;
  localparam int DEC_W           = 6;
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);

  // fixed-point constants
  localparam logic [20:0] GAIN_MAX     = 21'h1FFFFF;
  localparam logic [31:0] ENV_MIN      = 32'd2147;
  localparam logic [31:0] ENV_FLOOR    = 32'd3;
  localparam int          KNEE_HALF    = 768;
  localparam int          DB_PER_LOG2  = 394566;
  localparam int          LOG2_PER_DB  = 2786635;
  localparam int          DIV3_RECIP   = 43691;
  localparam int          CAP_W        = 46;
  localparam logic [CAP_W-1:0] CAP_NUM = 46'd56294995342131;
  localparam logic [23:0] GAIN_ONE_Q19 = 24'h080000;
  localparam logic [20:0] GAIN_ONE_Q16 = 21'h010000;
  localparam int          EXP_SAT      = 5 * 65536;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_SLOPE     = 3'd1,
    CFG_MAKEUP    = 3'd2,
    CFG_ATTACK    = 3'd3,
    CFG_RELEASE   = 3'd4,
    CFG_GAIN_UP   = 3'd5,
    CFG_GAIN_DOWN = 3'd6,
    CFG_ENGAGE    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [13:0] threshold_db;
    logic [15:0]        ratio_slope;
    logic [13:0]        makeup_db;
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic [15:0]        gain_up_coef;
    logic [15:0]        gain_down_coef;
    logic               engage;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold_db:   14'sd0,
    ratio_slope:    16'd0,
    makeup_db:      14'd0,
    attack_coef:    16'd272,
    release_coef:   16'd23,
    gain_up_coef:   16'd679,
    gain_down_coef: 16'd2674,
    engage:         1'b0
  };

  // one queued sample pair with its linked peak (Q1.31)
  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [31:0]        peak;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BYP, ST_ENV, ST_FLOOR, ST_NORM, ST_LOG, ST_DB, ST_OVER,
    ST_RED1, ST_RED2, ST_RED3, ST_RED4, ST_LIN, ST_EXP0, ST_EXP, ST_SHIFT,
    ST_DIV, ST_CAP, ST_SMOOTH, ST_MUL_L, ST_MUL_R, ST_RND_R, ST_DONE
  } back_state_e;

  typedef logic [15:0] log_tab_t [LOG_TABLE_DEPTH];
  typedef logic [31:0] root_tab_t [16];

  // integer square root, bit-pair method
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    logic [63:0] vv;
    res = 64'd0;
    b   = 64'd1 << 62;
    vv  = v;
    while (b > vv) b = b >> 2;
    while (b != 64'd0) begin
      if (vv >= res + b) begin
        vv  = vv - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/depth) in Q16, by repeated squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
      r = 16'd0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd2 << 30)) begin
          r = r | 16'd1;
          x = x >> 1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  // 2^(2^-(k+1)) in Q30
  function automatic root_tab_t build_root_tab();
    root_tab_t   t;
    logic [63:0] v;
    v    = isqrt64(64'd1 << 61);
    t[0] = v[31:0];
    for (int k = 1; k < 16; k++) begin
      v    = isqrt64(v << 30);
      t[k] = v[31:0];
    end
    return t;
  endfunction

  localparam log_tab_t  LOG_TAB  = build_log_tab();
  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage
`default_nettype wire

// ----- rtl/ssk_front.sv -----
// Front end: takes input beats, forms the linked peak and queues the pair.
`default_nettype none
module ssk_front (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [23:0] left_in_i,
  input  wire logic signed [23:0] right_in_i,
  input  wire ssk_pkg::q_stat_t   q_stat_i,
  output logic                    push_o,
  output ssk_pkg::item_t          item_o
);

  logic [23:0] abs_l;
  logic [23:0] abs_r;
  logic [23:0] abs_max;

  // magnitude of each channel, 2^23 fits unsigned
  always_comb begin
    abs_l   = left_in_i[23]  ? 24'(-left_in_i)  : 24'(left_in_i);
    abs_r   = right_in_i[23] ? 24'(-right_in_i) : 24'(right_in_i);
    abs_max = (abs_l > abs_r) ? abs_l : abs_r;
  end

  // queue write
  assign in_ready_o   = !q_stat_i.full;
  assign push_o       = in_valid_i && !q_stat_i.full;
  assign item_o.left  = left_in_i;
  assign item_o.right = right_in_i;
  assign item_o.peak  = {abs_max, 8'd0};

endmodule
`default_nettype wire

// ----- rtl/ssk_fifo.sv -----
// Short queue of sample pairs between the front end and the gain engine.
`default_nettype none
module ssk_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ssk_pkg::item_t   item_i,
  input  wire logic             pop_i,
  output ssk_pkg::item_t        item_o,
  output ssk_pkg::q_stat_t      stat_o
);

  ssk_pkg::item_t                 mem_q [ssk_pkg::Q_DEPTH];
  logic [ssk_pkg::Q_AW-1:0]       wptr_q, wptr_d;
  logic [ssk_pkg::Q_AW-1:0]       rptr_q, rptr_d;
  logic [ssk_pkg::Q_CW-1:0]       cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  // pointer and fill bookkeeping
  always_comb begin
    do_push = push_i && (cnt_q != ssk_pkg::Q_CW'(ssk_pkg::Q_DEPTH));
    do_pop  = pop_i && (cnt_q != '0);
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == ssk_pkg::Q_AW'(ssk_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == ssk_pkg::Q_AW'(ssk_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == ssk_pkg::Q_CW'(ssk_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

// ----- rtl/ssk_back.sv -----
// Gain engine: envelope, decimated target gain, smoothing and output scaling, or bypass.
`default_nettype none
module ssk_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssk_pkg::cfg_t      cfg_i,
  input  wire ssk_pkg::item_t     item_i,
  input  wire logic               item_valid_i,
  output logic                    item_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      left_out_o,
  output logic signed [23:0]      right_out_o,
  output logic [20:0]             applied_gain_o
);

  ssk_pkg::back_state_e state_q, state_d;

  // model state
  logic [31:0]                 env_q;
  logic [23:0]                 g_q;
  logic [20:0]                 tgt_q;
  logic [ssk_pkg::DEC_W-1:0]   dec_q;
  logic                        out_valid_q;

  // working registers
  ssk_pkg::item_t              cur_q;
  logic signed [47:0]          acc_q;
  logic [31:0]                 e_q;
  logic [31:0]                 x_q;
  logic [4:0]                  p_q;
  logic signed [21:0]          l2_q;
  logic signed [18:0]          over_q;
  logic [17:0]                 red_q;
  logic signed [9:0]           n_q;
  logic [15:0]                 f_q;
  logic [31:0]                 m_q;
  logic [3:0]                  k_q;
  logic [20:0]                 gexp_q;
  logic [31:0]                 rem_q;
  logic [ssk_pkg::CAP_W-1:0]   quo_q;
  logic [5:0]                  dcnt_q;
  logic signed [23:0]          res_l_q;
  logic signed [23:0]          res_r_q;
  logic signed [23:0]          out_l_q;
  logic signed [23:0]          out_r_q;
  logic [20:0]                 out_g_q;

  // combinational helpers
  logic [31:0]        env_diff;
  logic [47:0]        env_prod;
  logic [31:0]        env_upd;
  logic [31:0]        e_new;
  logic signed [47:0] db_full;
  logic [33:0]        hi_prod;
  logic [10:0]        knee_t;
  logic signed [19:0] total;
  logic signed [47:0] ex;
  logic signed [10:0] sh;
  logic [31:0]        m_shift;
  logic [20:0]        gexp_new;
  logic [63:0]        root_prod;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic [23:0]        t_g;
  logic [23:0]        g_diff;
  logic [39:0]        g_prod;
  logic [23:0]        g_upd;
  logic signed [47:0] mul_l;
  logic signed [47:0] mul_r;
  logic signed [23:0] sat_acc;
  logic               out_load;

  // round half away from zero, then shift right
  function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
                                                 input int unsigned s);
    logic [47:0] mag;
    mag = v[47] ? 48'(-v) : 48'(v);
    mag = (mag + (48'd1 << (s - 1))) >> s;
    return v[47] ? -$signed(mag) : $signed(mag);
  endfunction

  // datapath arithmetic
  always_comb begin
    // envelope step
    if (cur_q.peak > env_q) begin
      env_diff = cur_q.peak - env_q;
      env_prod = 48'(env_diff) * 48'(cfg_i.attack_coef);
      env_upd  = env_q + env_prod[47:16];
    end else begin
      env_diff = env_q - cur_q.peak;
      env_prod = 48'(env_diff) * 48'(cfg_i.release_coef);
      env_upd  = env_q - env_prod[47:16];
    end
    e_new = (env_q < ssk_pkg::ENV_MIN) ? ssk_pkg::ENV_MIN : env_q;

    // knee
    db_full = rnd_shr(acc_q, 24);
    hi_prod = 34'(over_q[17:0]) * 34'(cfg_i.ratio_slope);
    knee_t  = 11'(over_q + 19'sd768);
    total   = $signed({6'd0, cfg_i.makeup_db}) - $signed({2'd0, red_q});

    // exponent and shift back to Q5.16
    ex        = rnd_shr(acc_q, 16);
    sh        = 11'sd14 - {n_q[9], n_q};
    m_shift   = (sh > 11'sd31) ? 32'd0 : (m_q >> sh[4:0]);
    gexp_new  = (m_shift > 32'(ssk_pkg::GAIN_MAX)) ? ssk_pkg::GAIN_MAX : m_shift[20:0];
    root_prod = 64'(m_q) * 64'(ssk_pkg::ROOT_TAB[k_q]);

    // restoring divider step
    rem_sh = {rem_q, ssk_pkg::CAP_NUM[dcnt_q]};
    rem_ge = (rem_sh >= {1'b0, e_q});

    // gain smoothing
    t_g = {tgt_q, 3'd0};
    if (t_g < g_q) begin
      g_diff = g_q - t_g;
      g_prod = 40'(g_diff) * 40'(cfg_i.gain_down_coef);
      g_upd  = g_q - g_prod[39:16];
    end else begin
      g_diff = t_g - g_q;
      g_prod = 40'(g_diff) * 40'(cfg_i.gain_up_coef);
      g_upd  = g_q + g_prod[39:16];
    end

    // output scaling
    mul_l = $signed({{24{cur_q.left[23]}}, cur_q.left}) * $signed({27'd0, g_q[23:3]});
    mul_r = $signed({{24{cur_q.right[23]}}, cur_q.right}) * $signed({27'd0, g_q[23:3]});
    if (rnd_shr(acc_q, 16) > 48'sd8388607) begin
      sat_acc = 24'sh7FFFFF;
    end else if (rnd_shr(acc_q, 16) < -48'sd8388608) begin
      sat_acc = 24'sh800000;
    end else begin
      sat_acc = 24'(rnd_shr(acc_q, 16));
    end
  end

  // sequencer: next state and handshake
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ssk_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = cfg_i.engage ? ssk_pkg::ST_ENV : ssk_pkg::ST_BYP;
        end
      end
      ssk_pkg::ST_BYP:   state_d = ssk_pkg::ST_DONE;
      ssk_pkg::ST_ENV:   state_d = (dec_q == '0) ? ssk_pkg::ST_FLOOR : ssk_pkg::ST_SMOOTH;
      ssk_pkg::ST_FLOOR: state_d = ssk_pkg::ST_NORM;
      ssk_pkg::ST_NORM:  state_d = x_q[31] ? ssk_pkg::ST_LOG : ssk_pkg::ST_NORM;
      ssk_pkg::ST_LOG:   state_d = ssk_pkg::ST_DB;
      ssk_pkg::ST_DB:    state_d = ssk_pkg::ST_OVER;
      ssk_pkg::ST_OVER:  state_d = ssk_pkg::ST_RED1;
      ssk_pkg::ST_RED1: begin
        if (over_q >= 19'sd768 || over_q <= -19'sd768) begin
          state_d = ssk_pkg::ST_LIN;
        end else begin
          state_d = ssk_pkg::ST_RED2;
        end
      end
      ssk_pkg::ST_RED2:  state_d = ssk_pkg::ST_RED3;
      ssk_pkg::ST_RED3:  state_d = ssk_pkg::ST_RED4;
      ssk_pkg::ST_RED4:  state_d = ssk_pkg::ST_LIN;
      ssk_pkg::ST_LIN:   state_d = ssk_pkg::ST_EXP0;
      ssk_pkg::ST_EXP0: begin
        state_d = (ex >= 48'(ssk_pkg::EXP_SAT)) ? ssk_pkg::ST_DIV : ssk_pkg::ST_EXP;
      end
      ssk_pkg::ST_EXP:   state_d = (k_q == 4'd15) ? ssk_pkg::ST_SHIFT : ssk_pkg::ST_EXP;
      ssk_pkg::ST_SHIFT: state_d = ssk_pkg::ST_DIV;
      ssk_pkg::ST_DIV:   state_d = (dcnt_q == '0) ? ssk_pkg::ST_CAP : ssk_pkg::ST_DIV;
      ssk_pkg::ST_CAP:   state_d = ssk_pkg::ST_SMOOTH;
      ssk_pkg::ST_SMOOTH: state_d = ssk_pkg::ST_MUL_L;
      ssk_pkg::ST_MUL_L: state_d = ssk_pkg::ST_MUL_R;
      ssk_pkg::ST_MUL_R: state_d = ssk_pkg::ST_RND_R;
      ssk_pkg::ST_RND_R: state_d = ssk_pkg::ST_DONE;
      ssk_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ssk_pkg::ST_IDLE;
        end
      end
      default: state_d = ssk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // compressor state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      g_q         <= ssk_pkg::GAIN_ONE_Q19;
      tgt_q       <= ssk_pkg::GAIN_ONE_Q16;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ssk_pkg::ST_BYP: begin
          if (g_q != ssk_pkg::GAIN_ONE_Q19) begin
            g_q   <= ssk_pkg::GAIN_ONE_Q19;
            tgt_q <= ssk_pkg::GAIN_ONE_Q16;
            env_q <= '0;
            dec_q <= '0;
          end
        end
        ssk_pkg::ST_ENV: begin
          env_q <= env_upd;
          if (dec_q == '0) begin
            dec_q <= ssk_pkg::DEC_W'(ssk_pkg::DECIMATE - 1);
          end else begin
            dec_q <= dec_q - 1'b1;
          end
        end
        ssk_pkg::ST_FLOOR: begin
          if (env_q < ssk_pkg::ENV_FLOOR) begin
            env_q <= '0;
          end
        end
        ssk_pkg::ST_CAP: begin
          if ({25'd0, gexp_q} > quo_q) begin
            tgt_q <= quo_q[20:0];
          end else begin
            tgt_q <= gexp_q;
          end
        end
        ssk_pkg::ST_SMOOTH: g_q <= g_upd;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ssk_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          cur_q <= item_i;
        end
      end
      ssk_pkg::ST_BYP: begin
        res_l_q <= cur_q.left;
        res_r_q <= cur_q.right;
      end
      ssk_pkg::ST_FLOOR: begin
        e_q <= e_new;
        x_q <= e_new;
        p_q <= 5'd31;
      end
      ssk_pkg::ST_NORM: begin
        if (!x_q[31]) begin
          x_q <= x_q << 1;
          p_q <= p_q - 1'b1;
        end
      end
      ssk_pkg::ST_LOG: begin
        // integer part p-31 above the Q16 table fraction
        l2_q <= {6'({1'b0, p_q} - 6'd31),
                 ssk_pkg::LOG_TAB[x_q[30 -: ssk_pkg::LOG_IDX_W]]};
      end
      ssk_pkg::ST_DB: begin
        acc_q <= $signed({{26{l2_q[21]}}, l2_q}) * $signed(48'(ssk_pkg::DB_PER_LOG2));
      end
      ssk_pkg::ST_OVER: begin
        over_q <= $signed(db_full[18:0]) - $signed({{5{cfg_i.threshold_db[13]}},
                                                    cfg_i.threshold_db});
      end
      ssk_pkg::ST_RED1: begin
        if (over_q >= 19'sd768) begin
          red_q <= hi_prod[33:16];
        end else if (over_q > -19'sd768) begin
          acc_q <= $signed({26'd0, 22'(knee_t) * 22'(knee_t)});
        end else begin
          red_q <= '0;
        end
      end
      ssk_pkg::ST_RED2: begin
        acc_q <= $signed(48'(acc_q[21:0]) * 48'(cfg_i.ratio_slope));
      end
      ssk_pkg::ST_RED3: begin
        // divide by 3 through the reciprocal
        acc_q <= $signed(48'(acc_q[37:26]) * 48'(ssk_pkg::DIV3_RECIP));
      end
      ssk_pkg::ST_RED4: red_q <= 18'(acc_q[28:17]);
      ssk_pkg::ST_LIN: begin
        acc_q <= $signed({{28{total[19]}}, total}) * $signed(48'(ssk_pkg::LOG2_PER_DB));
      end
      ssk_pkg::ST_EXP0: begin
        n_q    <= ex[25:16];
        f_q    <= ex[15:0];
        m_q    <= 32'd1 << 30;
        k_q    <= '0;
        gexp_q <= ssk_pkg::GAIN_MAX;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'(ssk_pkg::CAP_W - 1);
      end
      ssk_pkg::ST_EXP: begin
        if (f_q[4'd15 - k_q]) begin
          m_q <= root_prod[61:30];
        end
        k_q <= k_q + 1'b1;
      end
      ssk_pkg::ST_SHIFT: gexp_q <= gexp_new;
      ssk_pkg::ST_DIV: begin
        rem_q  <= rem_ge ? 32'(rem_sh - {1'b0, e_q}) : rem_sh[31:0];
        quo_q  <= {quo_q[ssk_pkg::CAP_W-2:0], rem_ge};
        dcnt_q <= dcnt_q - 1'b1;
      end
      ssk_pkg::ST_MUL_L: acc_q <= mul_l;
      ssk_pkg::ST_MUL_R: begin
        res_l_q <= sat_acc;
        acc_q   <= mul_r;
      end
      ssk_pkg::ST_RND_R: res_r_q <= sat_acc;
      ssk_pkg::ST_DONE: begin
        if (out_load) begin
          out_l_q <= res_l_q;
          out_r_q <= res_r_q;
          out_g_q <= g_q[23:3];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = out_l_q;
  assign right_out_o    = out_r_q;
  assign applied_gain_o = out_g_q;

endmodule
`default_nettype wire

// ----- rtl/stereo_soft_knee_compressor.sv -----
// Stereo soft-knee compressor: config registers, front end, queue and gain engine.
//
// Input channel: in_valid_i/in_ready_o carry one stereo Q1.23 pair per beat.
// Output channel: out_valid_o/out_ready_i carry the scaled pair and the
// applied Q5.16 gain per beat, one output beat for every input beat, in order.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once; write
// only while no beat is in flight.
// Sequence: an engaged pair passes envelope, gain smoothing, left and right
// scaling and the output register; a bypass pair goes unscaled to the output
// register. On every 16th engaged pair the target gain is rebuilt first:
// leading-one search, dB and knee, 2^x through one root multiply per bit unless
// it saturates, and the serial divider for the envelope cap.
// The single sequencer in the gain engine handles one pair at a time and pops
// the next pair only after the last one has gone to the output register.
// Reset: config registers take their defaults, envelope clears, gain is 1.0.
// Receiver stall: the finished beat waits in the output register; a two-entry
// queue keeps taking input beats until it fills, then in_ready_o drops.
`default_nettype none
`include "stereo_soft_knee_compressor_defines.svh"
module stereo_soft_knee_compressor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [23:0] left_in_i,
  input  wire logic signed [23:0] right_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [23:0]      left_out_o,
  output logic signed [23:0]      right_out_o,
  output logic [20:0]             applied_gain_o
);

  ssk_pkg::cfg_t    cfg_q, cfg_d;
  ssk_pkg::item_t   push_item;
  ssk_pkg::item_t   pop_item;
  ssk_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ssk_pkg::cfg_idx_e'(cfg_idx_i))
        ssk_pkg::CFG_THRESHOLD: cfg_d.threshold_db   = cfg_wdata_i[13:0];
        ssk_pkg::CFG_SLOPE:     cfg_d.ratio_slope    = cfg_wdata_i;
        ssk_pkg::CFG_MAKEUP:    cfg_d.makeup_db      = cfg_wdata_i[13:0];
        ssk_pkg::CFG_ATTACK:    cfg_d.attack_coef    = cfg_wdata_i;
        ssk_pkg::CFG_RELEASE:   cfg_d.release_coef   = cfg_wdata_i;
        ssk_pkg::CFG_GAIN_UP:   cfg_d.gain_up_coef   = cfg_wdata_i;
        ssk_pkg::CFG_GAIN_DOWN: cfg_d.gain_down_coef = cfg_wdata_i;
        ssk_pkg::CFG_ENGAGE:    cfg_d.engage         = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ssk_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssk_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .left_in_i  (left_in_i),
    .right_in_i (right_in_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (push_item)
  );

  ssk_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (q_stat)
  );

  ssk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_i         (pop_item),
    .item_valid_i   (!q_stat.empty),
    .item_pop_o     (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .applied_gain_o (applied_gain_o)
  );

  // checks
  `SSK_ASSERT_SAME(a_bypass_unity, out_valid_o && !cfg_q.engage, applied_gain_o == ssk_pkg::GAIN_ONE_Q16, "bypass beat without unity gain")
  `SSK_ASSERT_NEXT(a_push_lands, in_valid_i && in_ready_o && q_stat.empty, !q_stat.empty, "accepted beat missing from queue")

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the stereo soft-knee compressor.
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [20:0]        gain;
  } pair_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] left_in_i = '0;
  logic signed [23:0] right_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [23:0] left_out_o;
  logic signed [23:0] right_out_o;
  logic [20:0]        applied_gain_o;

  stereo_soft_knee_compressor uut (.*);

  initial forever #6 clk_i = ~clk_i;

  // shadow of the block: tables, registers, state
  longint log2_rom [ssk_pkg::LOG_TABLE_DEPTH];
  longint root_rom [16];
  longint thr_db, slope, makeup, atk, rel, g_up, g_dn, eng;
  longint env, sgain, tgain, dcount;

  pair_out_t expected_q [$];
  int  fail_cnt = 0;
  int  idle_cnt = 0;
  bit  no_idle = 1'b0;
  bit  long_hold_req = 1'b0;
  int  rx_stall = 0;

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic void make_roms();
    longint x, r;
    for (int i = 0; i < ssk_pkg::LOG_TABLE_DEPTH; i++) begin
      x = (longint'(1) << 30) + ((longint'(i) << 30) / ssk_pkg::LOG_TABLE_DEPTH);
      r = 0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (longint'(2) << 30)) begin
          r = r | 1;
          x = x >> 1;
        end
      end
      log2_rom[i] = r;
    end
    root_rom[0] = int_sqrt(64'd1 << 61);
    for (int k = 1; k < 16; k++) root_rom[k] = int_sqrt(root_rom[k-1] << 30);
  endfunction

  // rounds half away from zero
  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >> s);
    return (v + half) >> s;
  endfunction

  function automatic longint pow2_q16(longint ex);
    longint n, f, m, g;
    m = longint'(1) << 30;
    if (ex >= ssk_pkg::EXP_SAT) return ssk_pkg::GAIN_MAX;
    if (ex >= 0) begin
      n = ex >> 16;
      f = ex & 16'hFFFF;
    end else begin
      n = -((-ex + 65535) >> 16);
      f = ex - n * 65536;
    end
    for (int k = 0; k < 16; k++)
      if ((f >> (15 - k)) & 1) m = (m * root_rom[k]) >> 30;
    if (14 - n > 40) return 0;
    g = m >> (14 - n);
    return (g > ssk_pkg::GAIN_MAX) ? ssk_pkg::GAIN_MAX : g;
  endfunction

  // gain target from the current envelope
  function automatic void refresh_target();
    longint e, p, mant, idx, l2, db, over, red, total, g, cap, t;
    p = 0;
    red = 0;
    if (env < ssk_pkg::ENV_FLOOR) env = 0;
    e = (env < ssk_pkg::ENV_MIN) ? ssk_pkg::ENV_MIN : env;
    for (int i = 0; i < 32; i++) if ((e >> i) & 1) p = i;
    mant = (e << (31 - p)) & 64'h7FFF_FFFF;
    idx = (mant * ssk_pkg::LOG_TABLE_DEPTH) >> 31;
    l2 = (p - 31) * 65536 + log2_rom[idx];
    db = round_shift(l2 * ssk_pkg::DB_PER_LOG2, 24);
    over = db - thr_db;
    if (over >= ssk_pkg::KNEE_HALF) begin
      red = (over * slope) >> 16;
    end else if (over > -ssk_pkg::KNEE_HALF) begin
      t = over + ssk_pkg::KNEE_HALF;
      red = (t * t * slope) / 201326592;
    end
    total = makeup - red;
    g = pow2_q16(round_shift(total * ssk_pkg::LOG2_PER_DB, 16));
    cap = longint'(ssk_pkg::CAP_NUM) / e;
    if (g > cap) g = cap;
    tgain = (g > ssk_pkg::GAIN_MAX) ? ssk_pkg::GAIN_MAX : g;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // expected output beat for one accepted input beat
  function automatic pair_out_t compress_pair(logic signed [23:0] li, logic signed [23:0] ri);
    pair_out_t o;
    longint l, r, al, ar, peak, g, t, gq;
    l = li;
    r = ri;
    if (eng == 0) begin
      if (sgain != (1 << 19)) begin
        sgain = 1 << 19;
        tgain = 1 << 16;
        env = 0;
        dcount = 0;
      end
      o.left = li;
      o.right = ri;
      o.gain = 21'(sgain >> 3);
      return o;
    end
    al = (l < 0) ? -l : l;
    ar = (r < 0) ? -r : r;
    peak = ((al > ar) ? al : ar) << 8;
    if (peak > env) env = (env + (((peak - env) * atk) >> 16)) & 64'hFFFF_FFFF;
    else env = (env - (((env - peak) * rel) >> 16)) & 64'hFFFF_FFFF;
    if (dcount == 0) begin
      refresh_target();
      dcount = (ssk_pkg::DECIMATE - 1) & 63;
    end else begin
      dcount = (dcount - 1) & 63;
    end
    g = sgain;
    t = tgain << 3;
    if (t < g) g = g - (((g - t) * g_dn) >> 16);
    else g = g + (((t - g) * g_up) >> 16);
    sgain = g & 64'hFF_FFFF;
    gq = sgain >> 3;
    o.left = 24'(sat24(round_shift(l * gq, 16)));
    o.right = 24'(sat24(round_shift(r * gq, 16)));
    o.gain = 21'(gq);
    return o;
  endfunction

  // register write, shadowed in the predictor
  task automatic write_reg(ssk_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ssk_pkg::CFG_THRESHOLD: thr_db = longint'($signed(val[13:0]));
      ssk_pkg::CFG_SLOPE:     slope = val;
      ssk_pkg::CFG_MAKEUP:    makeup = val[13:0];
      ssk_pkg::CFG_ATTACK:    atk = val;
      ssk_pkg::CFG_RELEASE:   rel = val;
      ssk_pkg::CFG_GAIN_UP:   g_up = val;
      ssk_pkg::CFG_GAIN_DOWN: g_dn = val;
      ssk_pkg::CFG_ENGAGE:    eng = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid and wait until every expected beat is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(compress_pair(l, r));
  endtask

  task automatic set_all(logic [15:0] thr, logic [15:0] slp, logic [15:0] mk, logic [15:0] a,
                         logic [15:0] rl, logic [15:0] up, logic [15:0] dn, logic [15:0] en);
    write_reg(ssk_pkg::CFG_THRESHOLD, thr);
    write_reg(ssk_pkg::CFG_SLOPE, slp);
    write_reg(ssk_pkg::CFG_MAKEUP, mk);
    write_reg(ssk_pkg::CFG_ATTACK, a);
    write_reg(ssk_pkg::CFG_RELEASE, rl);
    write_reg(ssk_pkg::CFG_GAIN_UP, up);
    write_reg(ssk_pkg::CFG_GAIN_DOWN, dn);
    write_reg(ssk_pkg::CFG_ENGAGE, en);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'd0;
      default: return 16'($urandom_range(1, 8000));
    endcase
  endfunction

  function automatic logic [15:0] pick_thr();
    case ($urandom_range(0, 4))
      0: return 16'(-8192);
      1: return 16'd0;
      2: return 16'($urandom);
      default: return 16'(-int'($urandom_range(0, 8192)));
    endcase
  endfunction

  // bursts of program-like material: a level per block, content random under it
  task automatic send_program(int count);
    int amp;
    amp = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 5))
          0: amp = 8388607;
          1: amp = $urandom_range(0, 64);
          2: amp = -1;
          default: amp = $urandom_range(1, 8388607);
        endcase
      end
      if (amp < 0)
        send_pair(24'($urandom), 24'($urandom));
      else
        send_pair(24'($urandom_range(0, 2 * amp) - amp), 24'($urandom_range(0, 2 * amp) - amp));
    end
  endtask

  task automatic test_bypass();
    set_all(16'd0, 16'd0, 16'd0, 16'd272, 16'd23, 16'd679, 16'd2674, 16'd0);
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'sh800000, 24'sh7FFFFF);
    send_pair(24'sd0, 24'sd0);
    send_pair(-24'sd1, 24'sd1);
    drain();
  endtask

  task automatic test_engaged_extremes();
    set_all(16'(-4096), 16'd49152, 16'd1536, 16'd30000, 16'd200, 16'd4000, 16'd9000, 16'd1);
    for (int i = 0; i < 6; i++) send_pair(24'sh7FFFFF, 24'sh800000);
    for (int i = 0; i < 4; i++) send_pair(24'sd0, 24'sd0);
    send_pair(24'sh800000, 24'sd5);
    send_pair(24'sd1, -24'sd1);
    drain();
  endtask

  // zero coefficients freeze; makeup overflow saturates
  task automatic test_frozen_and_saturation();
    set_all(16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd1);
    for (int i = 0; i < 4; i++) send_pair(24'sh400000, -24'sh400000);
    drain();
    set_all(16'h1FFF, 16'd58982, 16'h3FFF, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1);
    for (int i = 0; i < 4; i++) send_pair(24'sh7FFFFF, 24'sh7FFFFF);
    drain();
    write_reg(ssk_pkg::CFG_ENGAGE, 16'd0);
    send_pair(24'sh123456, -24'sh654321);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph == 3);
      set_all(pick_thr(), (ph % 3 == 0) ? 16'd58982 : 16'($urandom), 16'($urandom_range(0, 8192)),
              pick_coef(), pick_coef(), pick_coef(), pick_coef(),
              (ph % 4 == 1) ? 16'd0 : 16'd1);
      if (ph == 5) long_hold_req = 1'b1;
      send_program(150);
      drain();
    end
    no_idle = 1'b0;
  endtask

  // receiver: random back-pressure, one long hold on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pair_out_t e;
    if (out_valid_o && out_ready_i) begin
      rx_stall = no_idle ? 0 : $urandom_range(0, 9);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat L=%0d R=%0d G=%0d", $time, left_out_o, right_out_o,
                 applied_gain_o);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (left_out_o !== e.left || right_out_o !== e.right || applied_gain_o !== e.gain) begin
          $display("%0t: mismatch expected L=%0d R=%0d G=%0d actual L=%0d R=%0d G=%0d", $time,
                   e.left, e.right, e.gain, left_out_o, right_out_o, applied_gain_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    make_roms();
    thr_db = 0; slope = 0; makeup = 0; atk = 272; rel = 23; g_up = 679; g_dn = 2674; eng = 0;
    env = 0; sgain = 1 << 19; tgain = 1 << 16; dcount = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_bypass();
    test_engaged_extremes();
    test_frozen_and_saturation();
    test_random_phases();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
